@@ design/wsbl_pkg.sv @@
`timescale 1ns / 1ps

package wsbl_pkg;

   localparam int LIST_DEPTH  = 1024;
   localparam int BLOCK_COUNT = 1024;
   localparam int LIST_AW     = $clog2(LIST_DEPTH);
   localparam int BLOCK_AW    = $clog2(BLOCK_COUNT);

   localparam int CMD_W   = 3;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 10;
   localparam int PTR_W   = 11;
   localparam int COUNT_W = 8;
   localparam int SLOT_W  = 10;

   localparam logic [PTR_W-1:0]        LIST_SIZE_RESET = 11'd1024;
   localparam logic signed [PTR_W-1:0] HEAD_RESET      = 11'sd1023;

   typedef enum logic [CMD_W-1:0] {
      CMD_MAP_WR   = 3'd0,
      CMD_CNT_WR   = 3'd1,
      CMD_TAIL_SET = 3'd2,
      CMD_HEAD_SET = 3'd3,
      CMD_INSERT   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY_MAP,
      S_KEY_CNT,
      S_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef struct packed {
      logic               we;
      logic [LIST_AW-1:0] waddr;
      logic [INDEX_W-1:0] wdata;
      logic [LIST_AW-1:0] raddr;
   } list_port_type;

   typedef struct packed {
      logic                we;
      logic [BLOCK_AW-1:0] waddr;
      logic [VALUE_W-1:0]  wdata;
      logic [BLOCK_AW-1:0] raddr;
   } map_port_type;

   typedef struct packed {
      logic                we;
      logic [BLOCK_AW-1:0] waddr;
      logic [COUNT_W-1:0]  wdata;
      logic [BLOCK_AW-1:0] raddr;
   } cnt_port_type;

endpackage

@@ design/wsbl_ram.sv @@
`timescale 1ns / 1ps

module wsbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/wsbl_ctrl.sv @@
`timescale 1ns / 1ps

module wsbl_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  wsbl_pkg::req_type            req_data,
   output logic                         req_stall,
   input  logic [wsbl_pkg::PTR_W-1:0]   list_size,
   input  logic                         out_free,
   output logic                         res_valid,
   output wsbl_pkg::rsp_type            res_data,
   output wsbl_pkg::list_port_type      list_port,
   input  logic [wsbl_pkg::INDEX_W-1:0] list_rdata,
   output wsbl_pkg::map_port_type       map_port,
   input  logic [wsbl_pkg::VALUE_W-1:0] map_rdata,
   output wsbl_pkg::cnt_port_type       cnt_port,
   input  logic [wsbl_pkg::COUNT_W-1:0] cnt_rdata
);

   wsbl_pkg::state_type                state_ff, state_in;
   logic signed [wsbl_pkg::PTR_W-1:0]  head_ff, head_in;
   logic [wsbl_pkg::PTR_W-1:0]         tail_ff, tail_in;
   logic [wsbl_pkg::COUNT_W-1:0]       key_ff, key_in;
   logic [wsbl_pkg::INDEX_W-1:0]       idx_ff, idx_in;
   logic [wsbl_pkg::LIST_AW-1:0]       pos_ff, pos_in;
   logic [wsbl_pkg::PTR_W-1:0]         probe_ff, probe_in;
   logic                               v1_ff, v1_in;
   logic                               v2_ff, v2_in;
   logic                               v3_ff, v3_in;
   logic [wsbl_pkg::INDEX_W-1:0]       e2_ff, e2_in;
   logic [wsbl_pkg::INDEX_W-1:0]       e3_ff, e3_in;
   logic [wsbl_pkg::PTR_W-1:0]         limit;
   logic                               accept;
   logic                               full;
   logic                               issue;

   assign limit  = (list_size > wsbl_pkg::PTR_W'(wsbl_pkg::LIST_DEPTH))
                 ? wsbl_pkg::PTR_W'(wsbl_pkg::LIST_DEPTH) : list_size;
   assign accept = req_valid && !req_stall;
   assign full   = $signed({head_ff[wsbl_pkg::PTR_W-1], head_ff})
                 < $signed({1'b0, tail_ff});
   assign issue  = probe_ff < limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsbl_pkg::S_IDLE;
         head_ff  <= wsbl_pkg::HEAD_RESET;
         tail_ff  <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      probe_ff <= probe_in;
      e2_ff    <= e2_in;
      e3_ff    <= e3_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      probe_in  = probe_ff;
      v1_in     = 1'b0;
      v2_in     = 1'b0;
      v3_in     = 1'b0;
      e2_in     = list_rdata;
      e3_in     = e2_ff;
      req_stall = 1'b1;
      res_valid = 1'b0;
      res_data  = '0;
      list_port = '0;
      map_port  = '0;
      cnt_port  = '0;

      unique case (state_ff)
         wsbl_pkg::S_IDLE: begin
            req_stall = !out_free;
            if (accept) begin
               res_valid = 1'b1;
               unique case (req_data.cmd)
                  wsbl_pkg::CMD_MAP_WR: begin
                     map_port.we    = 1'b1;
                     map_port.waddr = req_data.index[wsbl_pkg::BLOCK_AW-1:0];
                     map_port.wdata = req_data.value;
                  end
                  wsbl_pkg::CMD_CNT_WR: begin
                     cnt_port.we    = 1'b1;
                     cnt_port.waddr = req_data.index[wsbl_pkg::BLOCK_AW-1:0];
                     cnt_port.wdata = req_data.value[wsbl_pkg::COUNT_W-1:0];
                  end
                  wsbl_pkg::CMD_TAIL_SET: begin
                     tail_in = {1'b0, req_data.value};
                  end
                  wsbl_pkg::CMD_HEAD_SET: begin
                     head_in = $signed({1'b0, req_data.value});
                  end
                  wsbl_pkg::CMD_INSERT: begin
                     if (full) begin
                        res_data.status = 1'b1;
                     end else begin
                        res_valid      = 1'b0;
                        map_port.raddr = req_data.index[wsbl_pkg::BLOCK_AW-1:0];
                        idx_in         = req_data.index;
                        head_in        = head_ff - 11'sd1;
                        pos_in         = head_ff[wsbl_pkg::LIST_AW-1:0];
                        probe_in       = {1'b0, head_ff[wsbl_pkg::LIST_AW-1:0]} + 11'd1;
                        state_in       = wsbl_pkg::S_KEY_MAP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         wsbl_pkg::S_KEY_MAP: begin
            cnt_port.raddr = map_rdata[wsbl_pkg::BLOCK_AW-1:0];
            state_in       = wsbl_pkg::S_KEY_CNT;
         end
         wsbl_pkg::S_KEY_CNT: begin
            key_in   = cnt_rdata;
            state_in = wsbl_pkg::S_WALK;
         end
         wsbl_pkg::S_WALK: begin
            list_port.raddr = probe_ff[wsbl_pkg::LIST_AW-1:0];
            map_port.raddr  = list_rdata[wsbl_pkg::BLOCK_AW-1:0];
            cnt_port.raddr  = map_rdata[wsbl_pkg::BLOCK_AW-1:0];
            if (v3_ff && (cnt_rdata < key_ff)) begin
               // shift the smaller entry down one slot
               list_port.we    = 1'b1;
               list_port.waddr = pos_ff;
               list_port.wdata = e3_ff;
               pos_in          = pos_ff + 1'b1;
            end
            if ((v3_ff && !(cnt_rdata < key_ff)) || (!issue && !v1_ff && !v2_ff && !v3_ff))
            begin
               // place the new index into the hole and flush the walk
               list_port.we    = 1'b1;
               list_port.waddr = pos_ff;
               list_port.wdata = idx_ff;
               state_in        = wsbl_pkg::S_DONE;
            end else begin
               v1_in = issue;
               v2_in = v1_ff;
               v3_in = v2_ff;
               if (issue) begin
                  probe_in = probe_ff + 11'd1;
               end
            end
         end
         wsbl_pkg::S_DONE: begin
            if (out_free) begin
               res_valid     = 1'b1;
               res_data.slot = pos_ff;
               state_in      = wsbl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wsbl_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ design/wear_sorted_block_list_insert.sv @@
`timescale 1ns / 1ps

// Wear-sorted block list insertion.
// req_*: one command item (cmd, index, value); accepted when req_valid is high
//   and req_stall low. rsp_*: one result item (status, slot) per command, in
//   order, held in an output register while rsp_stall is high.
// csr_*: write of list_size; csr_ready is always high. Write only while idle.
// Table writes, pointer writes, unused commands and refused inserts give
//   their result in the cycle after acceptance.
// An accepted insert fetches the new key through the mapping and erase-count
//   memories, then walks the list with a 3-deep read pipeline (list, mapping,
//   erase count) that tests one entry per cycle. One item is worked on at a
//   time; a new item is taken only once the previous one is done and the
//   output register is free.
// While rsp_stall holds a result, req_stall stays high.
// Reset (synchronous) sets the head to 1023, the free tail to 0, list_size to
//   1024 and empties the output register. Memory contents are undefined until
//   written.

module wear_sorted_block_list_insert (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  wsbl_pkg::req_type          req_data,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output wsbl_pkg::rsp_type          rsp_data,
   input  logic                       rsp_stall,
   input  logic                       csr_valid,
   input  logic [wsbl_pkg::PTR_W-1:0] csr_data,
   output logic                       csr_ready
);

   logic [wsbl_pkg::PTR_W-1:0]   list_size_ff, list_size_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   wsbl_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                         out_free;
   logic                         res_valid;
   wsbl_pkg::rsp_type            res_data;
   wsbl_pkg::list_port_type      list_port;
   wsbl_pkg::map_port_type       map_port;
   wsbl_pkg::cnt_port_type       cnt_port;
   logic [wsbl_pkg::INDEX_W-1:0] list_rdata;
   logic [wsbl_pkg::VALUE_W-1:0] map_rdata;
   logic [wsbl_pkg::COUNT_W-1:0] cnt_rdata;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      list_size_in = list_size_ff;
      if (csr_valid && csr_ready) begin
         list_size_in = csr_data;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_size_ff <= wsbl_pkg::LIST_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         list_size_ff <= list_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   wsbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .list_size  (list_size_ff),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res_data   (res_data),
      .list_port  (list_port),
      .list_rdata (list_rdata),
      .map_port   (map_port),
      .map_rdata  (map_rdata),
      .cnt_port   (cnt_port),
      .cnt_rdata  (cnt_rdata)
   );

   wsbl_ram #(
      .WIDTH (wsbl_pkg::INDEX_W),
      .DEPTH (wsbl_pkg::LIST_DEPTH)
   ) u_list_ram (
      .clock (clock),
      .we    (list_port.we),
      .waddr (list_port.waddr),
      .wdata (list_port.wdata),
      .raddr (list_port.raddr),
      .rdata (list_rdata)
   );

   wsbl_ram #(
      .WIDTH (wsbl_pkg::VALUE_W),
      .DEPTH (wsbl_pkg::BLOCK_COUNT)
   ) u_map_ram (
      .clock (clock),
      .we    (map_port.we),
      .waddr (map_port.waddr),
      .wdata (map_port.wdata),
      .raddr (map_port.raddr),
      .rdata (map_rdata)
   );

   wsbl_ram #(
      .WIDTH (wsbl_pkg::COUNT_W),
      .DEPTH (wsbl_pkg::BLOCK_COUNT)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_port.we),
      .waddr (cnt_port.waddr),
      .wdata (cnt_port.wdata),
      .raddr (cnt_port.raddr),
      .rdata (cnt_rdata)
   );

endmodule

@@ tb/sv/wsbl_result_check.sv @@
`timescale 1ns / 1ps

module wsbl_result_check
   import wsbl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_data,
   input  logic             req_stall,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             rsp_stall,
   input  logic             csr_valid,
   input  logic [PTR_W-1:0] csr_data,
   input  logic             csr_ready,
   output int               open_items,
   output int               fail_count
);

   localparam logic STATUS_FULL = 1'b1;

   logic [VALUE_W-1:0] map_mem  [BLOCK_COUNT];
   logic [COUNT_W-1:0] wear_mem [BLOCK_COUNT];
   logic [INDEX_W-1:0] list_mem [LIST_DEPTH];
   int head_ptr;
   int tail_ptr;
   int size_cfg;
   rsp_type pending_results[$];

   initial begin
      open_items = 0;
      fail_count = 0;
      for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
         map_mem[i]  = '0;
         wear_mem[i] = '0;
      end
   end

   function automatic logic [COUNT_W-1:0] wear_of_entry(int unsigned entry);
      return wear_mem[map_mem[entry % BLOCK_COUNT] % BLOCK_COUNT];
   endfunction

   function automatic rsp_type run_command(req_type c);
      rsp_type r;
      int pos;
      int probe;
      int lim;
      logic [COUNT_W-1:0] key;
      r = '0;
      case (c.cmd)
         CMD_MAP_WR:   map_mem[c.index] = c.value;
         CMD_CNT_WR:   wear_mem[c.index] = c.value[COUNT_W-1:0];
         CMD_TAIL_SET: tail_ptr = int'(c.value);
         CMD_HEAD_SET: head_ptr = int'(c.value);
         CMD_INSERT: begin
            if (head_ptr < tail_ptr) begin
               r.status = STATUS_FULL;
            end else begin
               pos = head_ptr;
               lim = (size_cfg < LIST_DEPTH) ? size_cfg : LIST_DEPTH;
               key = wear_of_entry(32'(c.index));
               head_ptr--;
               probe = pos + 1;
               // shift lower-wear entries down to open the sorted place
               while (probe < lim && wear_of_entry(32'(list_mem[probe])) < key) begin
                  list_mem[pos % LIST_DEPTH] = list_mem[probe];
                  probe++;
                  pos++;
               end
               pos = pos % LIST_DEPTH;
               list_mem[pos] = c.index;
               r.slot = pos[SLOT_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic log_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected status %0d slot %0d, got status %0d slot %0d",
                  $realtime, what, want.status, want.slot, got.status, got.slot);
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         head_ptr = int'(HEAD_RESET);
         tail_ptr = 0;
         size_cfg = int'(LIST_SIZE_RESET);
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) size_cfg = int'(csr_data);
         if (req_valid && !req_stall) pending_results.push_back(run_command(req_data));
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_results.size() == 0) begin
               log_mismatch("result with none outstanding", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status || got.slot !== want.slot)
                  log_mismatch("result mismatch", want, got);
            end
         end
      end
      open_items <= pending_results.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import wsbl_pkg::*;

   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_LIMIT = 200000;
   localparam int PCT_BUSY    = 88;
   localparam int PCT_LIGHT   = 15;
   localparam int unsigned RUN_LIMIT_NS = 60_000_000;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   req_type          req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             rsp_stall = 1'b0;
   logic             csr_valid = 1'b0;
   logic [PTR_W-1:0] csr_data  = '0;
   logic             csr_ready;
   int               open_items;
   int               fail_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;

   bit map_ok  [BLOCK_COUNT];
   bit wear_ok [BLOCK_COUNT];
   bit slot_ok [LIST_DEPTH];
   int mapped_ids[$];
   int worn_ids[$];
   int head_s = int'(HEAD_RESET);
   int tail_s = 0;
   int size_s = int'(LIST_SIZE_RESET);

   wear_sorted_block_list_insert dut (.*);
   wsbl_result_check u_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      int holds_done;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   task automatic send_item(req_type item);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue(logic [CMD_W-1:0] cmd, int idx, int val);
      req_type item;
      item.cmd   = cmd;
      item.index = idx[INDEX_W-1:0];
      item.value = val[VALUE_W-1:0];
      send_item(item);
      case (cmd)
         CMD_MAP_WR: begin
            if (!map_ok[idx]) begin
               map_ok[idx] = 1'b1;
               mapped_ids.push_back(idx);
            end
         end
         CMD_CNT_WR: begin
            if (!wear_ok[idx]) begin
               wear_ok[idx] = 1'b1;
               worn_ids.push_back(idx);
            end
         end
         CMD_TAIL_SET: tail_s = val;
         CMD_HEAD_SET: head_s = val;
         CMD_INSERT: begin
            if (head_s >= tail_s) begin
               slot_ok[head_s] = 1'b1;
               head_s--;
            end
         end
         default: ;
      endcase
   endtask

   // lowest head for which every slot the walk can reach holds an item
   function automatic int ready_floor();
      int s;
      s = size_s - 1;
      while (s >= 0 && slot_ok[s]) s--;
      return s;
   endfunction

   task automatic put_map(int idx, int val);
      if (!wear_ok[val]) issue(CMD_CNT_WR, val, $urandom_range(1023));
      issue(CMD_MAP_WR, idx, val);
   endtask

   task automatic put_insert(int idx);
      if (head_s >= tail_s) begin
         if (head_s < ready_floor()) issue(CMD_HEAD_SET, $urandom_range(1023), size_s - 1);
         if (!map_ok[idx]) put_map(idx, $urandom_range(1023));
      end
      issue(CMD_INSERT, idx, $urandom_range(1023));
   endtask

   task automatic random_item();
      int pick;
      int idx;
      int lo;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if (mapped_ids.size() > 0 && $urandom_range(9) != 0)
            idx = mapped_ids[$urandom_range(mapped_ids.size() - 1)];
         else
            idx = $urandom_range(1023);
         put_insert(idx);
      end else if (pick < 65) begin
         if (mapped_ids.size() > 0 && $urandom_range(2) == 0)
            idx = mapped_ids[$urandom_range(mapped_ids.size() - 1)];
         else
            idx = $urandom_range(1023);
         put_map(idx, $urandom_range(1023));
      end else if (pick < 78) begin
         if (worn_ids.size() > 0 && $urandom_range(1) == 0)
            idx = worn_ids[$urandom_range(worn_ids.size() - 1)];
         else
            idx = $urandom_range(1023);
         issue(CMD_CNT_WR, idx, $urandom_range(1023));
      end else if (pick < 85) begin
         if ($urandom_range(9) < 7 && head_s > 0)
            issue(CMD_TAIL_SET, $urandom_range(1023), $urandom_range(head_s));
         else
            issue(CMD_TAIL_SET, $urandom_range(1023), $urandom_range(1023));
      end else if (pick < 95) begin
         lo = ready_floor();
         if (lo < 0) lo = 0;
         if ($urandom_range(9) < 7)
            issue(CMD_HEAD_SET, $urandom_range(1023), $urandom_range(size_s - 1, lo));
         else
            issue(CMD_HEAD_SET, $urandom_range(1023), $urandom_range(1023));
      end else begin
         issue(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), $urandom_range(1023),
               $urandom_range(1023));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_items != 0) @(posedge clock);
   endtask

   task automatic write_size(int v);
      csr_valid <= 1'b1;
      csr_data  <= v[PTR_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      size_s = v;
   endtask

   task automatic directed();
      issue(CMD_CNT_WR, 1023, 1023);
      issue(CMD_CNT_WR, 0, 0);
      issue(CMD_CNT_WR, 512, 'h180);
      issue(CMD_MAP_WR, 0, 0);
      issue(CMD_MAP_WR, 1023, 1023);
      issue(CMD_MAP_WR, 5, 512);
      issue(CMD_INSERT, 5, 0);
      issue(CMD_INSERT, 1023, 0);
      issue(CMD_INSERT, 0, 1023);
      issue(CMD_INSERT, 5, 0);
      issue(CMD_SPARE_LO, 1023, 1023);
      issue(CMD_SPARE_MID, 0, 0);
      issue(CMD_SPARE_HI, 682, 341);
      issue(CMD_TAIL_SET, 0, 1023);
      issue(CMD_INSERT, 0, 0);
      issue(CMD_INSERT, 777, 0);
      issue(CMD_TAIL_SET, 1023, 0);
      issue(CMD_HEAD_SET, 0, 1023);
      issue(CMD_INSERT, 0, 0);
      issue(CMD_CNT_WR, 512, 1023);
      issue(CMD_INSERT, 1023, 0);
   endtask

   task automatic run_phase(int size, int sidle, int rstall, int count, bit hold);
      wait_drained();
      write_size(size);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      issue(CMD_HEAD_SET, 0, size - 1);
      if (size == 1) begin
         // drive the head below zero, then insert against the signed head
         issue(CMD_TAIL_SET, 0, 0);
         put_insert(0);
         put_insert(5);
      end
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_drained();
         if (hold && i == 10) holds_asked++;
         random_item();
      end
   endtask

   initial begin : stimulus
      int waited;
      waited = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      directed();
      run_phase(1, 0, 0, 100, 1'b0);
      run_phase(1024, 0, 0, 40, 1'b0);
      run_phase(16, PCT_BUSY, 0, 150, 1'b0);
      run_phase(64, 0, PCT_BUSY, 150, 1'b0);
      run_phase(100, PCT_LIGHT, PCT_LIGHT, 200, 1'b0);
      run_phase(7, 0, 0, 150, 1'b1);
      run_phase(1024, PCT_LIGHT, PCT_LIGHT, 40, 1'b0);
      run_phase(33, PCT_BUSY, 0, 150, 1'b0);
      run_phase(2, 0, PCT_BUSY, 100, 1'b0);
      run_phase(500, PCT_LIGHT, PCT_LIGHT, 50, 1'b0);
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_items != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (open_items != 0) begin
         $display("Testbench completed WITH ERRORS");
      end else begin
         repeat (64) @(posedge clock);
         if (fail_count == 0)
            $display("Testbench completed without errors");
         else
            $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
